// File: hdl/whitespace_stego_extract_macros.svh
// ----------------------------------------------------------------------------
// Whitespace stego extractor assertion macros
// Shared clocked assertion forms used by the extractor RTL.
// ----------------------------------------------------------------------------
`ifndef WHITESPACE_STEGO_EXTRACT_MACROS_SVH
`define WHITESPACE_STEGO_EXTRACT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wse_pkg.sv
// ----------------------------------------------------------------------------
// Whitespace stego extractor package
// Widths, constants and shared types of the extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package wse_pkg;

  localparam int unsigned CharBits   = 7;
  localparam int unsigned CntW       = $clog2(CharBits + 1);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CharValueW = 7;

  localparam logic [ByteW-1:0] SpaceCode    = 8'd32;
  localparam logic [ByteW-1:0] GroupSizeRst = 8'd2;

  typedef enum logic {
    StatusChar  = 1'b0,
    StatusError = 1'b1
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             last_byte;
  } in_t;

  typedef struct packed {
    logic [CharValueW-1:0] char_value;
    status_e               status;
  } res_t;

  typedef struct packed {
    logic hit;
    logic halted;
    res_t res;
  } core_out_t;

endpackage

`default_nettype wire

// File: hdl/wse_in_if.sv
// ----------------------------------------------------------------------------
// Whitespace stego extractor input channel
// Valid/ready channel carrying one cover-text byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface wse_in_if;
  logic                       valid;
  logic                       ready;
  logic [wse_pkg::ByteW-1:0]  text_byte;
  logic                       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/wse_out_if.sv
// ----------------------------------------------------------------------------
// Whitespace stego extractor output channel
// Valid/ready channel carrying one recovered character or an error.
// ----------------------------------------------------------------------------
`default_nettype none

interface wse_out_if;
  logic                            valid;
  logic                            ready;
  logic [wse_pkg::CharValueW-1:0]  char_value;
  logic                            status;

  modport source (output valid, output char_value, output status, input ready);
  modport sink   (input valid, input char_value, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/wse_core.sv
// ----------------------------------------------------------------------------
// Whitespace stego extractor core
// Decoder state and the combinational update for one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wse_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [wse_pkg::ByteW-1:0] cfg_wdata_i,
  input  wire logic                      step_i,
  input  wire wse_pkg::in_t              item_i,
  output      wse_pkg::core_out_t        core_o
);

  logic [wse_pkg::ByteW-1:0]    group_size_q;
  logic                         pend_q, pend_d;
  logic [wse_pkg::ByteW-1:0]    gpos_q, gpos_d;
  logic                         half_valid_q, half_valid_d;
  logic                         half_value_q, half_value_d;
  logic [wse_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [wse_pkg::CharBits-1:0] shift_q, shift_d;
  logic                         halted_q, halted_d;

  logic                         is_space;
  logic                         have_bit;
  logic                         raw_bit;
  logic [wse_pkg::ByteW-1:0]    pos;
  logic                         keep;
  logic [wse_pkg::CntW-1:0]     cnt_inc;
  logic [wse_pkg::CharBits-1:0] shift_inc;
  logic                         hit;
  wse_pkg::res_t                res;

  assign is_space  = (item_i.text_byte == wse_pkg::SpaceCode);
  assign pos       = wse_pkg::ByteW'(gpos_q + 8'd1);
  assign keep      = (pos == 8'd1) || (pos == 8'd2);
  assign cnt_inc   = wse_pkg::CntW'(cnt_q + 1'b1);
  // Manchester 10 decodes to 1 and 01 to 0, so the decoded bit is the held half.
  assign shift_inc = {shift_q[wse_pkg::CharBits-2:0], half_value_q};

  always_comb begin
    pend_d       = pend_q;
    gpos_d       = gpos_q;
    half_valid_d = half_valid_q;
    half_value_d = half_value_q;
    cnt_d        = cnt_q;
    shift_d      = shift_q;
    halted_d     = halted_q;
    have_bit     = 1'b0;
    raw_bit      = 1'b0;
    hit          = 1'b0;
    res.char_value = '0;
    res.status     = wse_pkg::StatusChar;

    if (step_i && !halted_q) begin
      // A pending space pairs with this byte; a lone space in the last byte is single.
      if (pend_q) begin
        pend_d   = 1'b0;
        have_bit = 1'b1;
        raw_bit  = is_space;
      end else if (is_space) begin
        if (item_i.last_byte) begin
          have_bit = 1'b1;
        end else begin
          pend_d = 1'b1;
        end
      end
      if (item_i.last_byte) begin
        pend_d = 1'b0;
      end

      if (have_bit) begin
        gpos_d = (pos == group_size_q) ? '0 : pos;
        if (keep) begin
          if (!half_valid_q) begin
            half_valid_d = 1'b1;
            half_value_d = raw_bit;
          end else begin
            half_valid_d = 1'b0;
            if (half_value_q != raw_bit) begin
              if (cnt_inc == wse_pkg::CntW'(wse_pkg::CharBits)) begin
                hit            = 1'b1;
                res.char_value = wse_pkg::CharValueW'(shift_inc);
                shift_d        = '0;
                cnt_d          = '0;
              end else begin
                shift_d = shift_inc;
                cnt_d   = cnt_inc;
              end
            end else begin
              halted_d   = 1'b1;
              hit        = 1'b1;
              res.status = wse_pkg::StatusError;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= wse_pkg::GroupSizeRst;
      pend_q       <= 1'b0;
      gpos_q       <= '0;
      half_valid_q <= 1'b0;
      half_value_q <= 1'b0;
      cnt_q        <= '0;
      shift_q      <= '0;
      halted_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      pend_q       <= pend_d;
      gpos_q       <= gpos_d;
      half_valid_q <= half_valid_d;
      half_value_q <= half_value_d;
      cnt_q        <= cnt_d;
      shift_q      <= shift_d;
      halted_q     <= halted_d;
    end
  end

  assign core_o.hit    = hit;
  assign core_o.halted = halted_q;
  assign core_o.res    = res;

endmodule

`default_nettype wire

// File: hdl/whitespace_stego_extract.sv
// ----------------------------------------------------------------------------
// Whitespace stego extractor
// Recovers 7-bit characters hidden as single and double spaces in text.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                              Meaning
//  text_i    in   valid, ready, text_byte, last_byte   cover-text byte
//  char_o    out  valid, ready, char_value, status     character or error
//  cfg       in   cfg_we_i, cfg_wdata_i                group_size register
//
// One text byte is accepted every cycle while the decode stage does not stall.
// An accepted byte waits in the input register until it is decoded, and its
// result, if any, is then registered in the result register.
// Reset clears all decoder state and sets group_size to 2.
// A held result that is not taken stalls the decode stage; the input
// register then holds one more request before ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "whitespace_stego_extract_macros.svh"

module whitespace_stego_extract (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [wse_pkg::ByteW-1:0] cfg_wdata_i,
  wse_in_if.sink                         text_i,
  wse_out_if.source                      char_o
);

  wse_pkg::in_t       in_q;
  logic               in_valid_q, in_valid_d;
  wse_pkg::res_t      out_q;
  logic               out_valid_q, out_valid_d;
  logic               accept;
  logic               proc;
  wse_pkg::core_out_t core;

  assign proc         = in_valid_q && (!out_valid_q || char_o.ready);
  assign text_i.ready = !in_valid_q || proc;
  assign accept       = text_i.valid && text_i.ready;

  wse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (proc),
    .item_i      (in_q),
    .core_o      (core)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (core.hit) begin
      out_valid_d = 1'b1;
    end else if (char_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.text_byte <= text_i.text_byte;
      in_q.last_byte <= text_i.last_byte;
    end
    if (core.hit) begin
      out_q <= core.res;
    end
  end

  assign char_o.valid      = out_valid_q;
  assign char_o.char_value = out_q.char_value;
  assign char_o.status     = out_q.status;

  `WSE_ASSERT_NOW(a_hit_needs_step, core.hit, proc, "result produced without a decode step")
  `WSE_ASSERT_NOW(a_halted_silent, core.halted, !core.hit, "result produced while halted")
  `WSE_ASSERT_NEXT(a_error_halts, core.hit && (core.res.status == wse_pkg::StatusError),
                   core.halted, "error result did not halt decoding")
  `WSE_ASSERT_NOW(a_ready_only_on_stall, !text_i.ready,
                  in_valid_q && out_valid_q && !char_o.ready, "input blocked without a stall")

endmodule

`default_nettype wire

// File: test/tb_whitespace_stego_extract.sv
// ----------------------------------------------------------------------------
// Whitespace stego extractor testbench
// Feeds cover-text bytes through the valid/ready input channel, and mirrors
// the space-pair decoding, group selection and Manchester pairing in a
// predictor. Every character or error result is checked field by field. The
// group size steps through its extremes and several small values. The run
// ends with a broken pair, which must halt the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_whitespace_stego_extract;

  typedef enum int {GenClean, GenNoise, GenBreak} gen_mode_e;

  // Decoder mirror plus the queue of characters still owed by the block.
  class stego_char_predictor;
    logic [wse_pkg::ByteW-1:0]    group_size;
    logic                         space_pending;
    logic [7:0]                   group_position;
    logic                         half_valid;
    logic                         half_value;
    logic [wse_pkg::CntW-1:0]     char_bit_count;
    logic [wse_pkg::CharBits-1:0] char_shift;
    logic                         halted;
    wse_pkg::res_t                chars_due[$];
    int                           mismatches;
    int                           chars_seen;
    int                           errors_seen;

    function new();
      group_size     = wse_pkg::GroupSizeRst;
      space_pending  = 1'b0;
      group_position = '0;
      half_valid     = 1'b0;
      half_value     = 1'b0;
      char_bit_count = '0;
      char_shift     = '0;
      halted         = 1'b0;
      mismatches     = 0;
      chars_seen     = 0;
      errors_seen    = 0;
    endfunction

    // Raw bit formed by this byte, if any; the state is left alone.
    function void raw_of(input wse_pkg::in_t x, output bit have, output bit raw_bit);
      have    = 1'b0;
      raw_bit = 1'b0;
      if (space_pending) begin
        have    = 1'b1;
        raw_bit = (x.text_byte == wse_pkg::SpaceCode);
      end else if (x.text_byte == wse_pkg::SpaceCode && x.last_byte) begin
        have = 1'b1;
      end
    endfunction

    function bit would_halt(input wse_pkg::in_t x);
      bit         have;
      bit         raw_bit;
      logic [7:0] pos;
      if (halted) return 1'b0;
      raw_of(x, have, raw_bit);
      if (!have) return 1'b0;
      pos = group_position + 8'd1;
      return (pos == 8'd1 || pos == 8'd2) && half_valid && (half_value == raw_bit);
    endfunction

    function void note_byte(input wse_pkg::in_t x);
      bit            have;
      bit            raw_bit;
      logic [7:0]    pos;
      wse_pkg::res_t r;
      if (halted) return;
      raw_of(x, have, raw_bit);
      if (space_pending) space_pending = 1'b0;
      else if (x.text_byte == wse_pkg::SpaceCode) space_pending = 1'b1;
      if (x.last_byte) space_pending = 1'b0;
      if (!have) return;

      pos = group_position + 8'd1;
      group_position = (pos == group_size) ? 8'd0 : pos;
      if (!(pos == 8'd1 || pos == 8'd2)) return;
      if (!half_valid) begin
        half_valid = 1'b1;
        half_value = raw_bit;
        return;
      end
      half_valid = 1'b0;

      if (half_value == raw_bit) begin
        halted       = 1'b1;
        r.char_value = '0;
        r.status     = wse_pkg::StatusError;
        chars_due.push_back(r);
        return;
      end
      // A valid pair decodes to its first half: 10 gives 1 and 01 gives 0.
      char_shift     = {char_shift[wse_pkg::CharBits-2:0], half_value};
      char_bit_count = char_bit_count + 1'b1;
      if (char_bit_count >= wse_pkg::CharBits) begin
        r.char_value   = wse_pkg::CharValueW'(char_shift);
        r.status       = wse_pkg::StatusChar;
        chars_due.push_back(r);
        char_shift     = '0;
        char_bit_count = '0;
      end
    endfunction

    function void check_char(input wse_pkg::res_t got);
      wse_pkg::res_t want;
      if (chars_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result char %02h status %0d",
                   got.char_value, got.status);
        return;
      end
      want = chars_due.pop_front();
      if (want.status == wse_pkg::StatusError) errors_seen++;
      else chars_seen++;
      if (got.char_value !== want.char_value || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch: expected char %02h status %0d, got char %02h status %0d",
                   want.char_value, want.status, got.char_value, got.status);
      end
    endfunction

    function int pending();
      return chars_due.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [wse_pkg::ByteW-1:0] cfg_wdata_i;

  wse_in_if  text_if ();
  wse_out_if char_if ();

  whitespace_stego_extract DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .text_i      (text_if),
    .char_o      (char_if)
  );

  stego_char_predictor decoder = new();
  bit calm;
  int bytes_sent;
  int random_bytes;
  int group_writes;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 600000);
    $display("tb: failure");
    $finish;
  end

  // Result side: check at each edge, then pick ready for the next cycle.
  initial begin
    char_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (char_if.valid && char_if.ready) begin
        wse_pkg::res_t got;
        got.char_value = char_if.char_value;
        got.status     = wse_pkg::status_e'(char_if.status);
        decoder.check_char(got);
      end
      char_if.ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  function automatic wse_pkg::in_t pick_byte(gen_mode_e mode);
    wse_pkg::in_t c;
    for (int tries = 0; tries < 16; tries++) begin
      if (mode == GenNoise) begin
        c.text_byte = 8'($urandom_range(255));
        c.last_byte = ($urandom_range(3) == 0);
      end else begin
        c.text_byte = 8'($urandom_range(255));
        if (c.text_byte == wse_pkg::SpaceCode || $urandom_range(99) < 70)
          c.text_byte = wse_pkg::SpaceCode;
        c.last_byte = ($urandom_range(99) < 4);
      end
      if ((mode == GenBreak) == decoder.would_halt(c)) return c;
    end
    if (mode == GenBreak) return c;
    // One of a space and a non-space always completes a pair correctly.
    c.text_byte = wse_pkg::SpaceCode;
    c.last_byte = 1'b0;
    if (decoder.would_halt(c)) c.text_byte = 8'h41;
    return c;
  endfunction

  task automatic send_byte(input wse_pkg::in_t x);
    if (!calm)
      while ($urandom_range(99) < 23) begin
        text_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= x.text_byte;
    text_if.last_byte <= x.last_byte;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    decoder.note_byte(x);
    bytes_sent++;
  endtask

  // Holds off new requests until every owed result is out and the pipe is empty.
  task automatic drain();
    text_if.valid <= 1'b0;
    while (decoder.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_group(input logic [wse_pkg::ByteW-1:0] g);
    cfg_wdata_i <= g;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    decoder.group_size = g;
    group_writes++;
  endtask

  task automatic run_phase(input logic [wse_pkg::ByteW-1:0] g, input int n,
                           input bit quiet);
    drain();
    write_group(g);
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      send_byte(pick_byte(($urandom_range(99) < 20) ? GenNoise : GenClean));
      random_bytes++;
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [8:0]                opening[$];
    logic [wse_pkg::ByteW-1:0] g;
    bit                        paused;

    calm         = 1'b0;
    bytes_sent   = 0;
    random_bytes = 0;
    group_writes = 0;
    paused       = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    text_if.valid     <= 1'b0;
    text_if.text_byte <= '0;
    text_if.last_byte <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Opening sequence at the reset group size: byte extremes, bytes next to
    // the space code, a lone space on the last byte, and a pending space
    // closed by a last byte of either kind. It decodes to one character.
    opening = '{{8'h00, 1'b0}, {8'hff, 1'b1}, {wse_pkg::SpaceCode, 1'b1},
                {wse_pkg::SpaceCode, 1'b0}, {wse_pkg::SpaceCode, 1'b0},
                {wse_pkg::SpaceCode, 1'b0}, {wse_pkg::SpaceCode, 1'b0},
                {wse_pkg::SpaceCode, 1'b1}, {wse_pkg::SpaceCode, 1'b0}, {8'h21, 1'b1},
                {wse_pkg::SpaceCode, 1'b0}, {wse_pkg::SpaceCode, 1'b1},
                {wse_pkg::SpaceCode, 1'b0}, {8'h1f, 1'b0}, {wse_pkg::SpaceCode, 1'b0},
                {wse_pkg::SpaceCode, 1'b0}, {wse_pkg::SpaceCode, 1'b0},
                {wse_pkg::SpaceCode, 1'b0}, {8'ha0, 1'b0}, {wse_pkg::SpaceCode, 1'b1},
                {wse_pkg::SpaceCode, 1'b0}, {wse_pkg::SpaceCode, 1'b0},
                {wse_pkg::SpaceCode, 1'b1}, {wse_pkg::SpaceCode, 1'b0},
                {wse_pkg::SpaceCode, 1'b0}, {wse_pkg::SpaceCode, 1'b1}};
    foreach (opening[i]) send_byte(wse_pkg::in_t'(opening[i]));

    // Every raw bit kept, then a short odd group, then the two widest groups.
    run_phase(8'd1, 150, 1'b1);
    run_phase(8'd3, 120, 1'b0);
    run_phase(8'd255, 150, 1'b0);
    run_phase(8'd0, 560, 1'b0);

    while (random_bytes < 1050 || decoder.chars_seen + decoder.pending() < 40) begin
      g = ($urandom_range(3) == 0) ? 8'd1 : 8'($urandom_range(6, 2));
      drain();
      write_group(g);
      for (int i = 0; i < 100; i++) begin
        send_byte(pick_byte(($urandom_range(99) < 20) ? GenNoise : GenClean));
        random_bytes++;
        if (!paused && i == 50) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    // A broken pair halts decoding; the bytes after it must be ignored.
    drain();
    write_group(8'($urandom_range(4, 2)));
    while (!decoder.halted) send_byte(pick_byte(GenBreak));
    for (int i = 0; i < 20; i++) send_byte(pick_byte(GenNoise));

    text_if.valid <= 1'b0;
    while (decoder.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d text bytes sent over %0d group size settings", bytes_sent, group_writes);
    $display("tb: %0d characters and %0d error results checked, %0d mismatches",
             decoder.chars_seen, decoder.errors_seen, decoder.mismatches);
    if (decoder.mismatches == 0 && decoder.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
